// File: design/k_nearest_insertion_list_core_assert.svh
// assertion macros for the k-nearest insertion list checker
// no dependencies; included by the checker file only
`ifndef K_NEAREST_INSERTION_LIST_CORE_ASSERT_SVH
`define K_NEAREST_INSERTION_LIST_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define KNIL_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KNIL_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/knil_pkg.sv
// shared types and codes for the k-nearest insertion list
// no dependencies; used by the cell, the top level and the checker
package knil_pkg;

    // function codes of a request
    localparam logic FUNC_CLEAR = 1'b0;
    localparam logic FUNC_OFFER = 1'b1;

    // kinds of a result
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } t_cell_ctrl;

endpackage

// File: design/knil_in_if.sv
// request channel of the k-nearest insertion list
// no dependencies
interface knil_in_if #(
    parameter int DIST_BITS  = 32,
    parameter int LABEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [DIST_BITS-1:0]  distance;
    logic [LABEL_BITS-1:0] label;
    logic                  last;

    modport source (output valid, func, distance, label, last, input ready);
    modport sink   (input valid, func, distance, label, last, output ready);
endinterface

// File: design/knil_out_if.sv
// result channel of the k-nearest insertion list
// no dependencies
interface knil_out_if #(
    parameter int POS_BITS   = 5,
    parameter int DIST_BITS  = 32,
    parameter int LABEL_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [POS_BITS-1:0]   position;
    logic                  inserted;
    logic [DIST_BITS-1:0]  entry_distance;
    logic [LABEL_BITS-1:0] entry_label;
    logic                  entry_valid;
    logic                  end_of_run;

    modport source (output valid, kind, position, inserted, entry_distance, entry_label,
                    entry_valid, end_of_run, input ready);
    modport sink   (input valid, kind, position, inserted, entry_distance, entry_label,
                    entry_valid, end_of_run, output ready);
endinterface

// File: design/knil_cell.sv
// one slot of the insertion list: distance, label and valid flag
// depends on knil_pkg (t_cell_ctrl)
module knil_cell #(
    parameter int DIST_BITS  = 32,
    parameter int LABEL_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  knil_pkg::t_cell_ctrl   i_ctrl,
    input  logic                   i_active,
    input  logic [DIST_BITS-1:0]   i_cand_dist,
    input  logic [LABEL_BITS-1:0]  i_cand_label,
    input  logic                   i_prev_greater,
    input  logic [DIST_BITS-1:0]   i_prev_dist,
    input  logic [LABEL_BITS-1:0]  i_prev_label,
    input  logic                   i_prev_valid,
    input  logic [DIST_BITS-1:0]   i_next_dist,
    input  logic [LABEL_BITS-1:0]  i_next_label,
    input  logic                   i_next_valid,
    output logic                   o_greater,
    output logic [DIST_BITS-1:0]   o_dist,
    output logic [LABEL_BITS-1:0]  o_label,
    output logic                   o_valid
);
    logic [DIST_BITS-1:0]  r_dist;
    logic [LABEL_BITS-1:0] r_label;
    logic                  r_valid;
    logic [DIST_BITS-1:0]  n_dist;
    logic [LABEL_BITS-1:0] n_label;
    logic                  n_valid;

    // candidate lands before this slot's entry
    assign o_greater = i_cand_dist < r_dist;

    // slot update: clear, shift-in on insertion, or rotate during readout
    always_comb begin
        n_dist  = r_dist;
        n_label = r_label;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_dist  = '1;
            n_label = '0;
            n_valid = 1'b0;
        end else if (i_ctrl.insert && i_active && o_greater) begin
            if (i_prev_greater) begin
                n_dist  = i_prev_dist;
                n_label = i_prev_label;
                n_valid = i_prev_valid;
            end else begin
                n_dist  = i_cand_dist;
                n_label = i_cand_label;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.rotate && i_active) begin
            n_dist  = i_next_dist;
            n_label = i_next_label;
            n_valid = i_next_valid;
        end
    end

    // slot registers, emptied by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= '1;
            r_label <= '0;
            r_valid <= 1'b0;
        end else begin
            r_dist  <= n_dist;
            r_label <= n_label;
            r_valid <= n_valid;
        end
    end

    assign o_dist  = r_dist;
    assign o_label = r_label;
    assign o_valid = r_valid;
endmodule

// File: design/k_nearest_insertion_list_core.sv
// k-nearest insertion list: keeps the k smallest distances with their labels
// i_item (knil_in_if.sink) carries clear and offer requests; o_result
// (knil_out_if.source) carries insertion reports and list entries.
// i_cfg_we / i_cfg_data write k (0 counts as 1, above MAX_NEIGHBORS saturates).
// A clear request empties every slot and gives no result.
// An offer is compared against all slots at once; the report is registered
// and shown the cycle after acceptance, so offers flow at one per cycle
// while results are taken.
// An offer marked last is followed by k list entries, one per cycle while
// results are taken, read from the head cell while the active part of the
// chain rotates by one slot; no request is taken until the final entry is
// loaded.
// A stalled receiver holds the output register and blocks further requests.
// Reset (synchronous, active low) empties the list, sets k to 1 and drops
// any pending result.
module k_nearest_insertion_list_core #(
    parameter int MAX_NEIGHBORS = 16,
    parameter int DIST_BITS     = 32,
    parameter int LABEL_BITS    = 16,
    localparam int POS_BITS     = $clog2(MAX_NEIGHBORS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [POS_BITS-1:0] i_cfg_data,
    knil_in_if.sink             i_item,
    knil_out_if.source          o_result
);
    localparam logic [POS_BITS-1:0] K_MAX = POS_BITS'(MAX_NEIGHBORS);

    knil_pkg::t_state      r_state;
    knil_pkg::t_state      n_state;
    logic [POS_BITS-1:0]   r_k;
    logic [POS_BITS-1:0]   r_cnt;
    logic [POS_BITS-1:0]   n_cnt;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  load_report;
    logic                  load_entry;
    logic                  out_free;
    logic                  accept;
    logic [POS_BITS-1:0]   k_act;
    logic [POS_BITS-1:0]   k_last;
    logic [POS_BITS-1:0]   ins_pos;
    logic                  ins_hit;
    knil_pkg::t_cell_ctrl  ctrl;

    logic [MAX_NEIGHBORS-1:0] greater;
    logic [MAX_NEIGHBORS-1:0] active;
    logic [DIST_BITS-1:0]     c_dist  [MAX_NEIGHBORS];
    logic [LABEL_BITS-1:0]    c_label [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] c_valid;

    // result payload registers
    logic                  r_kind;
    logic [POS_BITS-1:0]   r_pos;
    logic                  r_ins;
    logic [DIST_BITS-1:0]  r_edist;
    logic [LABEL_BITS-1:0] r_elabel;
    logic                  r_evalid;
    logic                  r_end;

    // effective k
    always_comb begin
        k_act = r_k;
        if (r_k == '0) begin
            k_act = POS_BITS'(1);
        end else if (r_k > K_MAX) begin
            k_act = K_MAX;
        end
    end
    assign k_last = k_act - POS_BITS'(1);

    // first active slot that is greater than the candidate
    always_comb begin
        ins_pos = k_act;
        for (int i = MAX_NEIGHBORS - 1; i >= 0; i--) begin
            if (greater[i] && active[i]) begin
                ins_pos = POS_BITS'(i);
            end
        end
    end
    assign ins_hit = |(greater & active);

    // handshake
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == knil_pkg::ST_IDLE) && out_free;
    assign accept       = i_item.valid && i_item.ready;

    // controller: next state, cell commands and output loads
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        ctrl        = '0;
        load_report = 1'b0;
        load_entry  = 1'b0;
        case (r_state)
            knil_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_item.func == knil_pkg::FUNC_CLEAR) begin
                        ctrl.clear = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                        load_report = 1'b1;
                        if (i_item.last) begin
                            n_state = knil_pkg::ST_READOUT;
                            n_cnt   = '0;
                        end
                    end
                end
            end
            knil_pkg::ST_READOUT: begin
                if (out_free) begin
                    ctrl.rotate = 1'b1;
                    load_entry  = 1'b1;
                    n_cnt       = r_cnt + POS_BITS'(1);
                    if (r_cnt == k_last) begin
                        n_state = knil_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = knil_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = r_out_valid && !o_result.ready;
        if (load_report || load_entry) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= knil_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_k         <= POS_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_k <= i_cfg_data;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load_report) begin
            r_kind   <= knil_pkg::KIND_REPORT;
            r_pos    <= ins_pos;
            r_ins    <= ins_hit;
            r_edist  <= '0;
            r_elabel <= '0;
            r_evalid <= 1'b0;
            r_end    <= !i_item.last;
        end else if (load_entry) begin
            r_kind   <= knil_pkg::KIND_ENTRY;
            r_pos    <= r_cnt;
            r_ins    <= 1'b0;
            r_edist  <= c_dist[0];
            r_elabel <= c_valid[0] ? c_label[0] : '0;
            r_evalid <= c_valid[0];
            r_end    <= (r_cnt == k_last);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.kind           = r_kind;
    assign o_result.position       = r_pos;
    assign o_result.inserted       = r_ins;
    assign o_result.entry_distance = r_edist;
    assign o_result.entry_label    = r_elabel;
    assign o_result.entry_valid    = r_evalid;
    assign o_result.end_of_run     = r_end;

    // chain of slot cells
    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NXT  = (g == MAX_NEIGHBORS - 1) ? 0 : g + 1;

        logic                  prev_greater;
        logic                  wrap;
        logic [DIST_BITS-1:0]  next_dist;
        logic [LABEL_BITS-1:0] next_label;
        logic                  next_valid;

        assign active[g]    = POS_BITS'(g) < k_act;
        assign prev_greater = (g == 0) ? 1'b0 : greater[PREV];
        // last active slot takes the head entry during readout
        assign wrap         = (POS_BITS'(g) == k_last);
        assign next_dist    = wrap ? c_dist[0]  : c_dist[NXT];
        assign next_label   = wrap ? c_label[0] : c_label[NXT];
        assign next_valid   = wrap ? c_valid[0] : c_valid[NXT];

        knil_cell #(
            .DIST_BITS  (DIST_BITS),
            .LABEL_BITS (LABEL_BITS)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (ctrl),
            .i_active       (active[g]),
            .i_cand_dist    (i_item.distance),
            .i_cand_label   (i_item.label),
            .i_prev_greater (prev_greater),
            .i_prev_dist    (c_dist[PREV]),
            .i_prev_label   (c_label[PREV]),
            .i_prev_valid   (c_valid[PREV]),
            .i_next_dist    (next_dist),
            .i_next_label   (next_label),
            .i_next_valid   (next_valid),
            .o_greater      (greater[g]),
            .o_dist         (c_dist[g]),
            .o_label        (c_label[g]),
            .o_valid        (c_valid[g])
        );
    end
endmodule

// File: design/knil_checker.sv
// port-level checks for the k-nearest insertion list, bound to the top level
// depends on knil_pkg and k_nearest_insertion_list_core_assert.svh
`include "k_nearest_insertion_list_core_assert.svh"

module knil_checker #(
    parameter int POS_BITS = 5
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_func,
    input logic                i_in_last,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_kind,
    input logic [POS_BITS-1:0] i_out_position,
    input logic                i_out_end
);
    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // stalled result holds
    `KNIL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_kind) && $stable(i_out_position)
        && $stable(i_out_end), "stalled result changed")

    // a last offer gives a report that does not end the run
    `KNIL_ASSERT_NEXT(a_last_report, i_clk, i_rst_n,
        in_acc && (i_in_func == knil_pkg::FUNC_OFFER) && i_in_last,
        i_out_valid && (i_out_kind == knil_pkg::KIND_REPORT) && !i_out_end,
        "last offer did not give an open report")

    // readout starts with slot zero right after its report is taken
    `KNIL_ASSERT_NEXT(a_readout_start, i_clk, i_rst_n,
        out_acc && (i_out_kind == knil_pkg::KIND_REPORT) && !i_out_end,
        i_out_valid && (i_out_kind == knil_pkg::KIND_ENTRY) && (i_out_position == '0),
        "readout did not start at slot zero")

    // no request taken while a readout is unfinished
    `KNIL_ASSERT_NOW(a_busy_readout, i_clk, i_rst_n,
        i_out_valid && (i_out_kind == knil_pkg::KIND_ENTRY) && !i_out_end,
        !i_in_ready, "request channel ready during readout")
endmodule

bind k_nearest_insertion_list_core knil_checker #(
    .POS_BITS (POS_BITS)
) u_knil_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_in_func      (i_item.func),
    .i_in_last      (i_item.last),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_out_kind     (o_result.kind),
    .i_out_position (o_result.position),
    .i_out_end      (o_result.end_of_run)
);
